### hw/rtl/dtc_pkg.sv
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int SIDE_W  = 10;
    localparam int COUNT_W = 64;

    typedef struct packed {
        logic [SIDE_W-1:0] height;
        logic [SIDE_W-1:0] width;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] tiling_count;
        logic               too_wide;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ROW_RD,
        S_ROW_LD,
        S_WALK,
        S_ACC,
        S_FIN_RD,
        S_FIN_LD,
        S_DONE
    } t_state;

endpackage

### hw/rtl/dtc_stream_if.sv
`timescale 1ns / 1ps

interface dtc_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/domino_tiling_counter.sv
`timescale 1ns / 1ps

// Domino tiling counter: one word in (height, width), one word out (count mod 2^64,
// too_wide). With w the narrower side and r the longer one, an item first clears both
// count banks over the 2^w profiles, then for each of the r rows reads and zeroes each
// profile's count and, for each profile with a nonzero count, walks its placements on a
// stack, adding the count into the other bank for each completed placement; a final
// read, load and hand-off end the item. The count memory has one read and one write
// port, and the walk sequencer takes one step per cycle, apart from the accumulate
// step after each completed placement. A too-wide or odd-area grid goes straight to
// the hand-off. Input is taken only when idle.
module domino_tiling_counter
    import dtc_pkg::*;
#(
    parameter int MAX_WIDTH   = 10,
    parameter int STACK_DEPTH = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtc_stream_if.sink     i_in,
    dtc_stream_if.source   o_out
);

    localparam int MW  = MAX_WIDTH;
    localparam int AW  = MW + 1;
    localparam int MD  = 2 ** AW;
    localparam int NW  = $clog2(MW + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int TW  = $clog2(STACK_DEPTH + 1);

    t_state              r_state, n_state;
    logic [SIDE_W-1:0]   r_rows, n_rows;
    logic [SIDE_W-1:0]   r_row, n_row;
    logic [NW-1:0]       r_narrow, n_narrow;
    logic [MW:0]         r_masks, n_masks;
    logic [MW:0]         r_m, n_m;
    logic                r_phase, n_phase;
    logic                r_sel, n_sel;
    logic [COUNT_W-1:0]  r_amount, n_amount;
    logic [TW-1:0]       r_top, n_top;
    logic [NW-1:0]       r_stk_pos [STACK_DEPTH];
    logic [NW-1:0]       n_stk_pos [STACK_DEPTH];
    logic [MW-1:0]       r_stk_plc [STACK_DEPTH];
    logic [MW-1:0]       n_stk_plc [STACK_DEPTH];
    logic [MW-1:0]       r_acc_addr, n_acc_addr;
    t_out_item           r_res, n_res;
    logic                r_ovalid, n_ovalid;
    t_out_item           r_odata, n_odata;
    logic [COUNT_W-1:0]  r_rdata;

    logic [COUNT_W-1:0]  mem [MD];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [COUNT_W-1:0]  mem_wdata;

    logic                in_ready;
    logic                side_lt;
    logic [SIDE_W-1:0]   rows_in;
    logic [SIDE_W-1:0]   narrow_in;
    logic                wide_in;
    logic                odd_in;
    logic [SIW-1:0]      pop_idx;
    logic [NW-1:0]       e_pos;
    logic [MW-1:0]       e_plc;
    logic [NW-1:0]       pos_inc;
    logic [MW-1:0]       cur_mask;
    logic                bit_here;
    logic                bit_next;
    logic                m_last;
    logic                row_last;
    logic                adv;

    always_comb begin
        n_state    = r_state;
        n_rows     = r_rows;
        n_row      = r_row;
        n_narrow   = r_narrow;
        n_masks    = r_masks;
        n_m        = r_m;
        n_phase    = r_phase;
        n_sel      = r_sel;
        n_amount   = r_amount;
        n_top      = r_top;
        n_stk_pos  = r_stk_pos;
        n_stk_plc  = r_stk_plc;
        n_acc_addr = r_acc_addr;
        n_res      = r_res;
        n_odata    = r_odata;
        n_ovalid   = r_ovalid && !o_out.ready;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        adv        = 1'b0;
        in_ready   = (r_state == S_IDLE);

        side_lt   = i_in.data.height < i_in.data.width;
        rows_in   = side_lt ? i_in.data.width : i_in.data.height;
        narrow_in = side_lt ? i_in.data.height : i_in.data.width;
        wide_in   = narrow_in > SIDE_W'(MW);
        odd_in    = i_in.data.height[0] & i_in.data.width[0];

        pop_idx  = SIW'(r_top - 1'b1);
        e_pos    = r_stk_pos[pop_idx];
        e_plc    = r_stk_plc[pop_idx];
        pos_inc  = e_pos + 1'b1;
        cur_mask = r_m[MW-1:0];
        bit_here = |((cur_mask >> e_pos) & MW'(1));
        bit_next = |((cur_mask >> pos_inc) & MW'(1));
        m_last   = (r_m + 1'b1) == r_masks;
        row_last = (r_row + 1'b1) == r_rows;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rows   = rows_in;
                    n_narrow = NW'(narrow_in);
                    n_masks  = (MW + 1)'(1) << narrow_in;
                    n_m      = '0;
                    n_phase  = 1'b0;
                    n_sel    = 1'b0;
                    n_row    = '0;
                    if (wide_in) begin
                        n_res   = '{tiling_count: '0, too_wide: 1'b1};
                        n_state = S_DONE;
                    end else if (odd_in) begin
                        n_res   = '{tiling_count: '0, too_wide: 1'b0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_phase, r_m[MW-1:0]};
                mem_wdata = (!r_phase && r_m == '0) ? COUNT_W'(1) : '0;
                n_phase   = !r_phase;
                if (r_phase) begin
                    n_m = r_m + 1'b1;
                    if (m_last) begin
                        n_m     = '0;
                        n_state = (r_rows == '0) ? S_FIN_RD : S_ROW_RD;
                    end
                end
            end
            S_ROW_RD: begin
                // read the profile count and zero it so this bank is clean as next row target
                mem_raddr = {r_sel, r_m[MW-1:0]};
                mem_we    = 1'b1;
                mem_waddr = {r_sel, r_m[MW-1:0]};
                mem_wdata = '0;
                n_state   = S_ROW_LD;
            end
            S_ROW_LD: begin
                if (r_rdata != '0) begin
                    n_amount     = r_rdata;
                    n_top        = TW'(1);
                    n_stk_pos[0] = '0;
                    n_stk_plc[0] = '0;
                    n_state      = S_WALK;
                end else begin
                    adv = 1'b1;
                end
            end
            S_WALK: begin
                if (r_top == '0) begin
                    adv = 1'b1;
                end else if (e_pos >= r_narrow) begin
                    n_top      = r_top - 1'b1;
                    mem_raddr  = {!r_sel, e_plc};
                    n_acc_addr = e_plc;
                    n_state    = S_ACC;
                end else if (bit_here) begin
                    n_stk_pos[pop_idx] = pos_inc;
                end else begin
                    n_stk_pos[pop_idx] = pos_inc;
                    n_stk_plc[pop_idx] = e_plc | (MW'(1) << e_pos);
                    if (pos_inc < r_narrow && !bit_next && r_top < TW'(STACK_DEPTH)) begin
                        n_stk_pos[SIW'(r_top)] = e_pos + NW'(2);
                        n_stk_plc[SIW'(r_top)] = e_plc;
                        n_top                  = r_top + 1'b1;
                    end
                end
            end
            S_ACC: begin
                mem_we    = 1'b1;
                mem_waddr = {!r_sel, r_acc_addr};
                mem_wdata = r_rdata + r_amount;
                n_state   = S_WALK;
            end
            S_FIN_RD: begin
                mem_raddr = {r_sel, {MW{1'b0}}};
                n_state   = S_FIN_LD;
            end
            S_FIN_LD: begin
                n_res   = '{tiling_count: r_rdata, too_wide: 1'b0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (m_last) begin
                n_sel   = !r_sel;
                n_row   = r_row + 1'b1;
                n_m     = '0;
                n_state = row_last ? S_FIN_RD : S_ROW_RD;
            end else begin
                n_m     = r_m + 1'b1;
                n_state = S_ROW_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows     <= n_rows;
        r_row      <= n_row;
        r_narrow   <= n_narrow;
        r_masks    <= n_masks;
        r_m        <= n_m;
        r_phase    <= n_phase;
        r_sel      <= n_sel;
        r_amount   <= n_amount;
        r_stk_pos  <= n_stk_pos;
        r_stk_plc  <= n_stk_plc;
        r_acc_addr <= n_acc_addr;
        r_res      <= n_res;
        r_odata    <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

`ifndef ASSERT_OFF
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TW'(STACK_DEPTH))
        else $error("walk stack pointer past depth");

    a_acc_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |-> $past(r_state) == S_WALK)
        else $error("accumulate not preceded by a walk leaf");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_ACC || r_state == S_ROW_RD) |-> r_m < r_masks)
        else $error("profile index outside profile range");

    a_wide_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.too_wide) |-> o_out.data.tiling_count == '0)
        else $error("too-wide result with nonzero count");
`endif

endmodule

### test/tb_domino_tiling_counter.sv
`timescale 1ns / 1ps

module tb_domino_tiling_counter
    import dtc_pkg::*;
;

    localparam int MAX_W      = 10;
    localparam int STACK_D    = 12;
    localparam int IDLE_LIMIT = 2000000;
    localparam int HOLD_LEN   = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dtc_stream_if #(.t_payload(t_in_item))  in_if ();
    dtc_stream_if #(.t_payload(t_out_item)) out_if ();

    domino_tiling_counter #(
        .MAX_WIDTH  (MAX_W),
        .STACK_DEPTH(STACK_D)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_in_item  pending_grids[$];
    t_out_item expected_counts[$];

    int send_idle_pct = 8;
    int recv_idle_pct = 66;
    bit hold_request  = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int fail_count    = 0;
    int grids_queued  = 0;
    int counts_checked = 0;
    int n_too_wide    = 0;
    int n_odd         = 0;
    int n_zero_side   = 0;
    int n_counted     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Broken-profile count over the narrower side, wrapping at 64 bits.
    function automatic t_out_item count_tilings(t_in_item g);
        logic [COUNT_W-1:0] cur [0:1023];
        logic [COUNT_W-1:0] nxt [0:1023];
        int pos_stk  [0:15];
        int fill_stk [0:15];
        int a, b, n, rows, masks, sp, p, f, r, m, i;
        t_out_item res;
        res = '0;
        a = g.height;
        b = g.width;
        if (a < b) begin
            n = a;
            rows = b;
        end else begin
            n = b;
            rows = a;
        end
        if (n > MAX_W) begin
            res.too_wide = 1'b1;
            return res;
        end
        if ((a * b) % 2 == 1)
            return res;
        masks = 1 << n;
        for (i = 0; i < masks; i++)
            cur[i] = '0;
        cur[0] = 1;
        for (r = 0; r < rows; r++) begin
            for (i = 0; i < masks; i++)
                nxt[i] = '0;
            for (m = 0; m < masks; m++) begin
                if (cur[m] != 0) begin
                    sp = 1;
                    pos_stk[0] = 0;
                    fill_stk[0] = 0;
                    while (sp > 0) begin
                        sp--;
                        p = pos_stk[sp];
                        f = fill_stk[sp];
                        if (p >= n) begin
                            nxt[f] = nxt[f] + cur[m];
                        end else if ((m >> p) & 1) begin
                            pos_stk[sp] = p + 1;
                            fill_stk[sp] = f;
                            sp++;
                        end else begin
                            // vertical into next row
                            pos_stk[sp] = p + 1;
                            fill_stk[sp] = f | (1 << p);
                            sp++;
                            // horizontal pair
                            if (p + 1 < n && !((m >> (p + 1)) & 1)) begin
                                pos_stk[sp] = p + 2;
                                fill_stk[sp] = f;
                                sp++;
                            end
                        end
                    end
                end
            end
            for (i = 0; i < masks; i++)
                cur[i] = nxt[i];
        end
        res.tiling_count = cur[0];
        return res;
    endfunction

    task automatic add_grid(int h, int w);
        t_in_item g;
        int n;
        g.height = h[SIDE_W-1:0];
        g.width  = w[SIDE_W-1:0];
        pending_grids.push_back(g);
        grids_queued++;
        n = (h < w) ? h : w;
        if (n > MAX_W)
            n_too_wide++;
        else if ((h * w) % 2 == 1)
            n_odd++;
        else if (n == 0)
            n_zero_side++;
        else
            n_counted++;
    endtask

    task automatic add_random_grid();
        int kind, n, r;
        kind = $urandom_range(99);
        if (kind < 45) begin
            n = $urandom_range(5);
            if ($urandom_range(1))
                n = $urandom_range(3);
            r = $urandom_range(16);
        end else if (kind < 60) begin
            n = $urandom_range(2);
            r = $urandom_range(1023);
        end else if (kind < 64) begin
            n = ($urandom_range(3) == 0) ? 7 : 6;
            r = $urandom_range(6, 8);
        end else if (kind < 82) begin
            n = $urandom_range(11, 1023);
            r = $urandom_range(11, 1023);
        end else begin
            n = $urandom_range(1023) | 1;
            r = $urandom_range(1023) | 1;
        end
        if ($urandom_range(1))
            add_grid(n, r);
        else
            add_grid(r, n);
    endtask

    task automatic wait_drained();
        while (counts_checked < grids_queued)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_counts.push_back(count_tilings(in_if.data));
            if (!in_if.valid || in_if.ready) begin
                if (pending_grids.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pending_grids.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_LEN;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_counts
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result word: tiling_count %0d too_wide %0d",
                       out_if.data.tiling_count, out_if.data.too_wide);
                fail_count++;
            end else begin
                want = expected_counts.pop_front();
                if (out_if.data.tiling_count !== want.tiling_count) begin
                    $error("tiling_count: expected %0d, got %0d",
                           want.tiling_count, out_if.data.tiling_count);
                    fail_count++;
                end
                if (out_if.data.too_wide !== want.too_wide) begin
                    $error("too_wide: expected %0d, got %0d",
                           want.too_wide, out_if.data.too_wide);
                    fail_count++;
                end
            end
            counts_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 66;
        add_grid(0, 0);
        add_grid(0, 1023);
        add_grid(1023, 0);
        add_grid(1, 1);
        add_grid(1, 2);
        add_grid(2, 1);
        add_grid(2, 2);
        add_grid(3, 4);
        add_grid(1023, 1023);
        add_grid(11, 11);
        add_grid(11, 12);
        add_grid(1, 1023);
        add_grid(2, 1023);
        add_grid(1023, 2);
        add_grid(1022, 2);
        add_grid(512, 1);
        add_grid(1, 512);
        add_grid(4, 100);
        add_grid(6, 7);
        add_grid(8, 8);
        add_grid(10, 10);
        add_grid(3, 1023);
        repeat (20) add_random_grid();
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 8;
        hold_request = 1'b1;
        send_idle_pct = 0;
        add_grid(2, 3);
        add_grid(3, 2);
        add_grid(12, 20);
        add_grid(4, 4);
        add_grid(1, 6);
        wait_drained();
        send_idle_pct = 66;
        repeat (20) add_random_grid();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (30) add_random_grid();
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("%0d grids checked: %0d counted, %0d with a zero side,",
                 counts_checked, n_counted, n_zero_side);
        $display("%0d odd area, %0d too wide", n_odd, n_too_wide);
        $display("idle mixes covered sender/receiver stalls, one long output hold and full rate");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
